// ===== rtl/bpf_pkg.sv =====
// Shared types and constants of the bond propulsion force pipeline.
// No dependencies; the files that use it refer to it by scoped names.
package bpf_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MAGNITUDE  = 3'd0,
    REG_REVERSAL   = 3'd1,
    REG_MOL_COUNT  = 3'd2,
    REG_FLIP_PROB  = 3'd3,
    REG_TYPE_FLAGS = 3'd4,
    REG_NEWTON     = 3'd5
  } reg_idx_t;

  // Bond type flag codes (other codes act as off)
  localparam logic [1:0] FLAG_PLUS  = 2'b01;
  localparam logic [1:0] FLAG_MINUS = 2'b11;

  localparam logic [31:0] TYPE_FLAGS_RESET = 32'h5555_5555;
  localparam int SQRT_STAGES  = 8;
  localparam int DIV_STAGES   = 8;
  localparam int STEPS        = 4;

  typedef struct packed {
    logic signed [31:0] magnitude;
    logic               reversal;
    logic [10:0]        mol_count;
    logic [31:0]        flip_prob;
    logic [31:0]        type_flags;
    logic               newton;
  } cfg_t;

  // Control that travels with each word
  typedef struct packed {
    logic       v;
    logic       fz;
    logic       neg;
    logic       ap1;
    logic       ap2;
    logic       dirn;
    logic [2:0] dneg;
  } ctl_t;

  // Square root stage word
  typedef struct packed {
    ctl_t             ctl;
    logic [63:0]      rem;
    logic [63:0]      res;
    logic [2:0][63:0] num;
  } sq_t;

  // Divider stage word
  typedef struct packed {
    ctl_t             ctl;
    logic [32:0]      den;
    logic [2:0]       sat;
    logic [2:0][33:0] rem;
    logic [2:0][31:0] low;
    logic [2:0][31:0] q;
  } dv_t;

endpackage

// ===== rtl/bpf_if.sv =====
// Valid/ready channel interfaces for bond words in and force words out.
// Depends on nothing but the package convention.
interface bpf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [31:0]        tag_first;
  logic [31:0]        tag_second;
  logic [3:0]         bond_type;
  logic [15:0]        mol_first;
  logic [15:0]        mol_second;
  logic signed [31:0] disp_x;
  logic signed [31:0] disp_y;
  logic signed [31:0] disp_z;
  logic               group_match;
  logic [1:0]         local_flags;
  logic [31:0]        random_draw;

  modport source (output valid, action, tag_first, tag_second, bond_type, mol_first,
                  mol_second, disp_x, disp_y, disp_z, group_match, local_flags,
                  random_draw, input ready);
  modport sink   (input valid, action, tag_first, tag_second, bond_type, mol_first,
                  mol_second, disp_x, disp_y, disp_z, group_match, local_flags,
                  random_draw, output ready);
endinterface

interface bpf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic               apply_first;
  logic               apply_second;
  logic               direction_now;

  modport source (output valid, force_x, force_y, force_z, apply_first, apply_second,
                  direction_now, input ready);
  modport sink   (input valid, force_x, force_y, force_z, apply_first, apply_second,
                  direction_now, output ready);
endinterface

// ===== rtl/bpf_front.sv =====
// Front end: input register, direction table, sign decode, multipliers, sum of squares.
// Depends on bpf_pkg and bpf_in_if.
module bpf_front #(
  parameter int MAX_MOLECULES = 1024,
  parameter int BOND_TYPES    = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           take,
  input  bpf_pkg::cfg_t  cfg,
  bpf_in_if.sink         bonds,
  output logic           clearing,
  output bpf_pkg::sq_t   sq
);
  localparam int DEPTH = MAX_MOLECULES + 1;
  localparam int AW    = $clog2(DEPTH);

  logic              dir_mem [DEPTH];
  logic [AW-1:0]     clr_addr;
  logic              rd;
  logic [AW-1:0]     a_addr;
  logic [AW-1:0]     in_addr;
  logic              a_v;
  logic              a_action;
  logic [31:0]       a_tag1, a_tag2, a_draw;
  logic [3:0]        a_bt;
  logic [15:0]       a_mol1, a_mol2;
  logic [2:0][31:0]  a_d;
  logic              a_group;
  logic [1:0]        a_local;
  logic              lw_v;
  logic              lw_d;
  logic [AW-1:0]     lw_addr;

  bpf_pkg::ctl_t     b_ctl, b_ctl_next;
  bpf_pkg::ctl_t     c_ctl;
  logic [2:0][63:0]  b_sq, b_num;
  logic [2:0][63:0]  b_sq_next, b_num_next;

  logic              dir, in_range, toggle, newdir, wr, match, off, neg1;
  logic [1:0]        flag;
  logic [31:0]       amag;
  logic [2:0][31:0]  ad;
  logic [15:0]       cnt16;
  logic [63:0]       s_sum;

  // Clearing pass over the direction table after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) clearing <= 1'b0;
    end
  end

  assign in_addr = ({16'd0, bonds.mol_first} <= 32'(MAX_MOLECULES)) ?
                   bonds.mol_first[AW-1:0] : '0;

  // Stage A: capture word and read table
  always_ff @(posedge clk) begin
    if (en) begin
      a_action <= bonds.action;
      a_tag1   <= bonds.tag_first;
      a_tag2   <= bonds.tag_second;
      a_bt     <= bonds.bond_type;
      a_mol1   <= bonds.mol_first;
      a_mol2   <= bonds.mol_second;
      a_d      <= {bonds.disp_z, bonds.disp_y, bonds.disp_x};
      a_group  <= bonds.group_match;
      a_local  <= bonds.local_flags;
      a_draw   <= bonds.random_draw;
      a_addr   <= in_addr;
      rd       <= dir_mem[in_addr];
    end
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= take;
  end

  // Table write: clearing or flip result
  always_ff @(posedge clk) begin
    if (clearing) dir_mem[clr_addr] <= 1'b0;
    else if (en && wr) dir_mem[a_addr] <= newdir;
  end

  // Hold the last write for a read that raced it
  always_ff @(posedge clk) begin
    if (rst) lw_v <= 1'b0;
    else if (en && wr) begin
      lw_v    <= 1'b1;
      lw_d    <= newdir;
      lw_addr <= a_addr;
    end
  end

  // Decode sign, flip, apply flags
  always_comb begin
    cnt16    = {5'd0, cfg.mol_count};
    dir      = (lw_v && lw_addr == a_addr) ? lw_d : rd;
    in_range = {16'd0, a_mol1} <= 32'(MAX_MOLECULES);
    toggle   = cfg.reversal && (a_mol1 != 16'd0) && (a_mol1 <= cnt16) &&
               (a_draw <= cfg.flip_prob);
    newdir   = dir ^ toggle;
    wr       = a_v && a_action && in_range && toggle;
    flag     = ({28'd0, a_bt} < 32'(BOND_TYPES)) ? cfg.type_flags[2*a_bt +: 2] : 2'b00;
    off      = !(flag == bpf_pkg::FLAG_PLUS || flag == bpf_pkg::FLAG_MINUS);
    neg1     = !(a_tag1 > a_tag2) ^ (flag == bpf_pkg::FLAG_MINUS);
    match    = (a_mol1 == a_mol2) && (a_mol1 <= cnt16) && in_range;
    if (cfg.reversal) begin
      off  = off || !match;
      neg1 = neg1 ^ dir;
    end
    b_ctl_next.v    = a_v;
    b_ctl_next.fz   = a_action || !a_group || off;
    b_ctl_next.neg  = neg1 ^ cfg.magnitude[31];
    b_ctl_next.ap1  = !b_ctl_next.fz && (cfg.newton || a_local[0]);
    b_ctl_next.ap2  = !b_ctl_next.fz && (cfg.newton || a_local[1]);
    b_ctl_next.dirn = a_action && in_range && newdir;
    for (int i = 0; i < 3; i++) begin
      b_ctl_next.dneg[i] = a_d[i][31];
    end
  end

  // Multiply: squares and magnitude products
  always_comb begin
    amag = cfg.magnitude[31] ? 32'(-cfg.magnitude) : cfg.magnitude;
    for (int i = 0; i < 3; i++) begin
      ad[i]         = a_d[i][31] ? (32'd0 - a_d[i]) : a_d[i];
      b_sq_next[i]  = {32'd0, ad[i]} * {32'd0, ad[i]};
      b_num_next[i] = {32'd0, amag} * {32'd0, ad[i]};
    end
  end

  // Stage B
  always_ff @(posedge clk) begin
    if (rst) b_ctl.v <= 1'b0;
    else if (en) begin
      b_ctl <= b_ctl_next;
      b_sq  <= b_sq_next;
      b_num <= b_num_next;
    end
  end

  assign s_sum = b_sq[0] + b_sq[1] + b_sq[2];

  // Force zero on zero length
  always_comb begin
    c_ctl    = b_ctl;
    c_ctl.fz = b_ctl.fz || (s_sum == 64'd0);
  end

  // Stage C: sum of squares
  always_ff @(posedge clk) begin
    if (rst) sq.ctl.v <= 1'b0;
    else if (en) begin
      sq.ctl <= c_ctl;
      sq.rem <= s_sum;
      sq.res <= '0;
      sq.num <= b_num;
    end
  end

  assign bonds.ready = en && !clearing;

endmodule

// ===== rtl/bpf_sqrt_stage.sv =====
// One square root stage: four bit steps of the integer root, then a register.
// Depends on bpf_pkg.
module bpf_sqrt_stage #(
  parameter int FIRST = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  bpf_pkg::sq_t d,
  output bpf_pkg::sq_t q
);
  bpf_pkg::sq_t q_next;
  logic [63:0]  bitv;

  // Advance four root bits
  always_comb begin
    q_next = d;
    bitv   = '0;
    for (int i = 0; i < bpf_pkg::STEPS; i++) begin
      bitv = 64'd1 << (62 - 2 * (FIRST + i));
      if (q_next.rem >= q_next.res + bitv) begin
        q_next.rem = q_next.rem - (q_next.res + bitv);
        q_next.res = (q_next.res >> 1) + bitv;
      end else begin
        q_next.res = q_next.res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q.ctl.v <= 1'b0;
    else if (en) q <= q_next;
  end

endmodule

// ===== rtl/bpf_div_stage.sv =====
// One divider stage: four restoring quotient bits for all three components.
// Depends on bpf_pkg.
module bpf_div_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  bpf_pkg::dv_t d,
  output bpf_pkg::dv_t q
);
  bpf_pkg::dv_t q_next;
  logic [33:0]  r;

  // Shift in a dividend bit, subtract when it fits
  always_comb begin
    q_next = d;
    r      = '0;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < bpf_pkg::STEPS; i++) begin
        r = {q_next.rem[c][32:0], q_next.low[c][31]};
        q_next.low[c] = {q_next.low[c][30:0], 1'b0};
        if (r >= {1'b0, q_next.den}) begin
          q_next.rem[c] = r - {1'b0, q_next.den};
          q_next.q[c]   = {q_next.q[c][30:0], 1'b1};
        end else begin
          q_next.rem[c] = r;
          q_next.q[c]   = {q_next.q[c][30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q.ctl.v <= 1'b0;
    else if (en) q <= q_next;
  end

endmodule

// ===== rtl/bond_propulsion_force.sv =====
// Bond propulsion force pipeline, built around the 8-stage root and 8-stage divider;
// throughput one word per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or being taken.
// Reset (synchronous) clears valids and config registers, then a clearing pass
// zeroes all MAX_MOLECULES+1 direction table entries; no word is taken meanwhile.
module bond_propulsion_force #(
  parameter int MAX_MOLECULES = 1024,
  parameter int BOND_TYPES    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  bpf_in_if.sink      bonds,
  bpf_out_if.source   forces
);
  bpf_pkg::cfg_t cfg;
  logic          en, clearing, take;
  bpf_pkg::sq_t  sq_pipe [bpf_pkg::SQRT_STAGES + 1];
  bpf_pkg::dv_t  dv_pipe [bpf_pkg::DIV_STAGES + 1];
  bpf_pkg::dv_t  dv_first;
  logic [2:0][63:0] n;
  logic [31:0]   r;
  bpf_pkg::ctl_t o_ctl;
  logic [2:0][31:0] fval;
  logic [2:0][31:0] qc;
  logic [2:0][31:0] o_f;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magnitude  <= '0;
      cfg.reversal   <= 1'b0;
      cfg.mol_count  <= '0;
      cfg.flip_prob  <= '0;
      cfg.type_flags <= bpf_pkg::TYPE_FLAGS_RESET;
      cfg.newton     <= 1'b0;
    end else if (wr_en) begin
      case (bpf_pkg::reg_idx_t'(wr_index))
        bpf_pkg::REG_MAGNITUDE:  cfg.magnitude  <= wr_data;
        bpf_pkg::REG_REVERSAL:   cfg.reversal   <= wr_data[0];
        bpf_pkg::REG_MOL_COUNT:  cfg.mol_count  <= wr_data[10:0];
        bpf_pkg::REG_FLIP_PROB:  cfg.flip_prob  <= wr_data;
        bpf_pkg::REG_TYPE_FLAGS: cfg.type_flags <= wr_data;
        bpf_pkg::REG_NEWTON:     cfg.newton     <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Global advance
  assign en   = !o_ctl.v || forces.ready;
  assign take = bonds.valid && en && !clearing;

  bpf_front #(
    .MAX_MOLECULES(MAX_MOLECULES),
    .BOND_TYPES   (BOND_TYPES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .take    (take),
    .cfg     (cfg),
    .bonds   (bonds),
    .clearing(clearing),
    .sq      (sq_pipe[0])
  );

  // Integer square root stages
  for (genvar k = 0; k < bpf_pkg::SQRT_STAGES; k++) begin : g_sqrt
    bpf_sqrt_stage #(.FIRST(k * bpf_pkg::STEPS)) u_sqrt (
      .clk(clk), .rst(rst), .en(en), .d(sq_pipe[k]), .q(sq_pipe[k + 1])
    );
  end

  // Dividend and divisor setup: q = (num + r) / (2r), saturate if it needs 33 bits
  always_comb begin
    r            = sq_pipe[bpf_pkg::SQRT_STAGES].res[31:0];
    dv_first.ctl = sq_pipe[bpf_pkg::SQRT_STAGES].ctl;
    dv_first.den = {r, 1'b0};
    for (int c = 0; c < 3; c++) begin
      n[c]             = sq_pipe[bpf_pkg::SQRT_STAGES].num[c] + {32'd0, r};
      dv_first.sat[c]  = {1'b0, n[c][63:32]} >= dv_first.den;
      dv_first.rem[c]  = {2'b00, n[c][63:32]};
      dv_first.low[c]  = n[c][31:0];
      dv_first.q[c]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_pipe[0].ctl.v <= 1'b0;
    else if (en) dv_pipe[0] <= dv_first;
  end

  // Divider stages
  for (genvar k = 0; k < bpf_pkg::DIV_STAGES; k++) begin : g_div
    bpf_div_stage u_div (
      .clk(clk), .rst(rst), .en(en), .d(dv_pipe[k]), .q(dv_pipe[k + 1])
    );
  end

  // Clamp, apply sign, saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qc[c] = (dv_pipe[bpf_pkg::DIV_STAGES].sat[c] ||
               dv_pipe[bpf_pkg::DIV_STAGES].q[c] > 32'h8000_0000) ?
              32'h8000_0000 : dv_pipe[bpf_pkg::DIV_STAGES].q[c];
      if (dv_pipe[bpf_pkg::DIV_STAGES].ctl.fz) fval[c] = '0;
      else if (dv_pipe[bpf_pkg::DIV_STAGES].ctl.neg ^
               dv_pipe[bpf_pkg::DIV_STAGES].ctl.dneg[c]) fval[c] = 32'd0 - qc[c];
      else fval[c] = (qc[c] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qc[c];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) o_ctl.v <= 1'b0;
    else if (en) begin
      o_ctl <= dv_pipe[bpf_pkg::DIV_STAGES].ctl;
      o_f   <= fval;
    end
  end

  assign forces.valid         = o_ctl.v;
  assign forces.force_x       = o_f[0];
  assign forces.force_y       = o_f[1];
  assign forces.force_z       = o_f[2];
  assign forces.apply_first   = o_ctl.ap1;
  assign forces.apply_second  = o_ctl.ap2;
  assign forces.direction_now = o_ctl.dirn;

endmodule

// ===== rtl/bpf_checker.sv =====
// Port-level checks on the bond propulsion force block, bound to the top level.
// Depends on bond_propulsion_force and the channel interfaces.
module bpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] force_x,
  input logic        apply_first,
  input logic        apply_second,
  input logic        direction_now
);

  // Stalled result word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_x))
    else $error("result word dropped or changed under stall");

  // Clearing pass blocks input after reset
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during table clearing");

  // No result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Minus direction only comes from flip words, which carry no force
  a_flip: assert property (@(posedge clk) disable iff (rst)
    out_valid && direction_now |-> force_x == 32'd0 && !apply_first && !apply_second)
    else $error("flip word carries force");

endmodule

bind bond_propulsion_force bpf_checker u_bpf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (bonds.ready),
  .out_valid    (forces.valid),
  .out_ready    (forces.ready),
  .force_x      (forces.force_x),
  .apply_first  (forces.apply_first),
  .apply_second (forces.apply_second),
  .direction_now(forces.direction_now)
);
